>>> hdl/sha1d_pkg.sv
// Shared types and constants for the SHA-1 digest core.
// Used by the compression unit and the top level.
package sha1d_pkg;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;

	// Round counter marks of one compression: load, 80 rounds, final add.
	localparam logic [6:0] RND_LAST = 7'd80;
	localparam logic [6:0] RND_DONE = 7'd81;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

	typedef logic [4:0][31:0] chain_t;

	typedef struct packed {
		logic start;
		logic reinit;
	} comp_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} comp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COMP = 4'b0010,
		ST_PAD  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

endpackage

>>> hdl/sha1_message_digest_core.sv
// SHA-1 digest core: one message byte per request, five digest words per message.
// Every 64th byte starts a compression, during which no byte is taken.
// Ending a message adds the pad bytes, one or two compressions, then five words.
// Reset (arst_n low, asynchronous) loads the initial hash words and a zero length.
// The block buffer holds no reset value; only bytes of the current block are read.
module sha1_message_digest_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] byte_present
	input  logic        s_tlast,  // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] digest_word
	output logic [2:0]  m_tuser,  // [2:0] word_index
	output logic        m_tlast   // last_word
);
	import sha1d_pkg::*;

	state_t      state_q, ret_q;
	logic [63:0] bitlen_q;
	logic [63:0] len_q;
	logic        first_q;
	logic        lphase_q;
	logic [2:0]  lidx_q;
	logic [2:0]  oidx_q;

	logic        push_en;
	logic [7:0]  push_byte;
	logic [5:0]  pos;
	logic        lphase_now;
	logic        s_req;
	logic        m_req;
	logic [3:0]  raddr;
	logic [31:0] rdata;
	comp_ctrl_t  cctrl;
	comp_stat_t  cstat;
	chain_t      chain;

	// The fill position in the block is the byte count modulo 64.
	assign pos   = bitlen_q[8:3];
	assign s_req = s_tvalid && s_tready;
	assign m_req = m_tvalid && m_tready;

	// Length bytes begin once the zero padding has reached byte 56.
	assign lphase_now = lphase_q || (!first_q && pos == LEN_POS);

	// One byte enters the block per cycle outside compression and output: a message byte (when present) or a pad byte.
	always_comb begin
		push_en   = 1'b0;
		push_byte = s_tdata;
		unique case (state_q)
			ST_IDLE: begin
				push_en = s_req && s_tuser;
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (first_q) begin
					push_byte = PAD_MARK;
				end else if (lphase_now) begin
					push_byte = len_q[{~lidx_q, 3'b000} +: 8];
				end else begin
					push_byte = '0;
				end
			end
			ST_COMP, ST_OUT: begin
				push_en = 1'b0;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	// A full block starts the compression in the cycle its last byte is written.
	assign cctrl.start  = push_en && (pos == LAST_POS);
	assign cctrl.reinit = m_req && (oidx_q == LAST_WORD_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			bitlen_q <= '0;
			first_q  <= 1'b0;
			lphase_q <= 1'b0;
			lidx_q   <= '0;
			oidx_q   <= '0;
		end else begin
			if (push_en) begin
				bitlen_q <= bitlen_q + 64'd8;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_req) begin
						first_q  <= 1'b1;
						lphase_q <= 1'b0;
						lidx_q   <= '0;
						if (cctrl.start) begin
							state_q <= ST_COMP;
							ret_q   <= s_tlast ? ST_PAD : ST_IDLE;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (lphase_now) begin
						lphase_q <= 1'b1;
						lidx_q   <= lidx_q + 3'd1;
					end
					if (cctrl.start) begin
						state_q <= ST_COMP;
						ret_q   <= (lphase_now && lidx_q == 3'd7) ? ST_OUT : ST_PAD;
					end
				end
				ST_COMP: begin
					if (cstat.done) begin
						state_q <= ret_q;
					end
				end
				ST_OUT: begin
					if (m_req) begin
						if (oidx_q == LAST_WORD_IDX) begin
							oidx_q   <= '0;
							bitlen_q <= '0;
							state_q  <= ST_IDLE;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The length field is the bit count after the last message byte.
	always_ff @(posedge clk) begin
		if (s_req && s_tlast) begin
			len_q <= bitlen_q + (s_tuser ? 64'd8 : 64'd0);
		end
	end

	sha1d_blkmem u_mem (
		.clk   (clk),
		.wen   (push_en),
		.waddr (pos),
		.wdata (push_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	sha1d_compress u_comp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cctrl),
		.stat   (cstat),
		.raddr  (raddr),
		.rdata  (rdata),
		.chain  (chain)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = chain[oidx_q];
	assign m_tuser  = oidx_q;
	assign m_tlast  = (oidx_q == LAST_WORD_IDX);

endmodule

>>> hdl/sha1d_blkmem.sv
// Block buffer: 16 words of 32 bits, written one byte at a time, read one word.
// Depends on nothing; the read data is registered.
module sha1d_blkmem (
	input  logic        clk,
	input  logic        wen,
	input  logic [5:0]  waddr,
	input  logic [7:0]  wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [16];
	logic [31:0] rdata_q;

	// Byte 0 of a word is its most significant byte.
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr[5:2]][{~waddr[1:0], 3'b000} +: 8] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/sha1d_compress.sv
// SHA-1 compression unit: one round per cycle, message schedule in a shift line.
// Uses sha1d_pkg; reads the block words from sha1d_blkmem.
module sha1d_compress (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1d_pkg::comp_ctrl_t ctrl,
	output sha1d_pkg::comp_stat_t stat,
	output logic [3:0]           raddr,
	input  logic [31:0]          rdata,
	output sha1d_pkg::chain_t    chain
);
	import sha1d_pkg::*;

	chain_t      chain_q;
	logic        busy_q;
	logic [6:0]  rnd_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [31:0] wx, wi, f, k, t;

	always_comb begin
		wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		wi = (rnd_q <= 7'd16) ? rdata : {wx[30:0], wx[31]};
		if (rnd_q <= 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q <= 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q <= 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rnd_q   <= '0;
			chain_q <= {H4, H3, H2, H1, H0};
		end else begin
			if (ctrl.reinit) begin
				chain_q <= {H4, H3, H2, H1, H0};
			end
			if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				if (rnd_q == RND_DONE) begin
					busy_q     <= 1'b0;
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
				end
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (rnd_q == '0) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end else if (rnd_q <= RND_LAST) begin
				e_q <= d_q;
				d_q <= c_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				b_q <= a_q;
				a_q <= t;
				for (int j = 0; j < 15; j++) begin
					w_q[j] <= w_q[j+1];
				end
				w_q[15] <= wi;
			end
		end
	end

	assign raddr     = rnd_q[3:0];
	assign stat.busy = busy_q;
	assign stat.done = busy_q && (rnd_q == RND_DONE);
	assign chain     = chain_q;

endmodule

>>> hdl/sha1d_checker.sv
// Port-level checks for the SHA-1 digest core, attached by bind.
// Uses only the top level's ports.
module sha1d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// Input requests are not taken while digest words are on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest output is valid");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 3'd4)))
		else $error("last word flag does not match word index four");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= 3'd4))
		else $error("word index out of range");

	a_next_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tuser == $past(m_tuser) + 3'd1))
		else $error("digest words not in order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_core sha1d_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
